@@ rtl/core/svpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// svpwm_pkg
// Types, constants and helpers shared by the space-vector PWM duty core.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // widths of the internal fixed-point values
  localparam int unsigned W_SA = 34;   // sqrt3*alpha, Q31 signed
  localparam int unsigned W_T  = 36;   // x, y, z, t1, t2, Q32 signed
  localparam int unsigned W_ON = 38;   // doubled on-times, Q33 signed

  // sqrt3 in Q16, 113512
  localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;

  localparam logic signed [W_ON-1:0] ONE_Q32 = 38'sh01_0000_0000;
  localparam logic signed [W_ON-1:0] ONE_Q33 = 38'sh02_0000_0000;
  localparam logic [34:0]            ROUND_Q18 = 35'h0_0002_0000;
  localparam logic [15:0]            HALF_Q15 = 16'd16384;
  localparam logic [15:0]            FULL_Q15 = 16'd32768;

  // sector codes, 4c+2b+a from the projection signs
  localparam logic [2:0] SEC_ZERO = 3'd0;
  localparam logic [2:0] SEC_1    = 3'd1;
  localparam logic [2:0] SEC_2    = 3'd2;
  localparam logic [2:0] SEC_3    = 3'd3;
  localparam logic [2:0] SEC_4    = 3'd4;
  localparam logic [2:0] SEC_5    = 3'd5;
  localparam logic [2:0] SEC_6    = 3'd6;
  localparam logic [2:0] SEC_BAD  = 3'd7;

  typedef struct packed {
    logic signed [15:0] alpha_voltage;
    logic signed [15:0] beta_voltage;
  } svpwm_in_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
  } svpwm_out_t;

  // sector and vector times handed from the front end to the duty stages
  typedef struct packed {
    logic                   valid;
    logic [2:0]             sector;
    logic signed [W_T-1:0]  t1;
    logic signed [W_T-1:0]  t2;
  } svpwm_sel_t;

  // clamp a Q33 on-time to 0..1 and round it to unsigned Q1.15
  function automatic logic [15:0] to_q15(input logic signed [W_ON-1:0] v);
    logic [34:0] sum;
    sum = v[34:0] + ROUND_Q18;
    if (v < 0) begin
      return 16'd0;
    end else if (v > ONE_Q33) begin
      return FULL_Q15;
    end else begin
      return sum[33:18];
    end
  endfunction

endpackage

@@ rtl/core/space_vector_pwm_duty_core.sv @@
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_core
// Space-vector PWM duty generator: alpha/beta voltage in, sector, three
// Q1.15 phase duties and three timer compare counts out.
//
//   channel   ports                        direction  transfer when
//   input     start_i, busy_o, in_data_i   in         start_i high, busy_o low
//   result    result_valid_o, result_o     out        result_valid_o high
//   config    cfg_we_i, cfg_wdata_i        in         cfg_we_i high
//
// Six register stages: a new vector can be taken every cycle and its result
// strobes once it has passed all six. The depth is set by the sqrt3 multiply,
// the Y/Z adds, the sector select, the on-time adds, the clamp/round and the
// period multiply, one per stage. busy_o stays low; nothing stalls since the
// receiver always takes results. Reset clears only the valid bits and loads
// period_top with 65535.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  svpwm_pkg::svpwm_in_t   in_data_i,
  output logic                   result_valid_o,
  output svpwm_pkg::svpwm_out_t  result_o,
  input  logic                   cfg_we_i,
  input  logic [15:0]            cfg_wdata_i
);
  import svpwm_pkg::*;

  logic                   accept;
  svpwm_sel_t             sel;
  logic [15:0]            period_top_q;
  logic                   v4_q, v5_q, v6_q;
  logic [2:0]             sec4_q, sec5_q;
  logic signed [W_ON-1:0] ta_d, tb_d, tc_d, ta_q, tb_q, tc_q;
  logic [15:0]            qa, qb, qc;
  logic [15:0]            da_d, db_d, dc_d, da_q, db_q, dc_q;
  logic [31:0]            pa, pb, pc;
  svpwm_out_t             res_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_top_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      period_top_q <= cfg_wdata_i;
    end
  end

  // stages 1 to 3: sector and vector times
  svpwm_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .in_i    (in_data_i),
    .sel_o   (sel)
  );

  // stage 4: doubled on-times in Q33
  assign ta_d = ONE_Q32 - W_ON'(sel.t1) - W_ON'(sel.t2);
  assign tb_d = ONE_Q32 + W_ON'(sel.t1) - W_ON'(sel.t2);
  assign tc_d = ONE_Q32 + W_ON'(sel.t1) + W_ON'(sel.t2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v4_q <= sel.valid;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ta_q   <= ta_d;
    tb_q   <= tb_d;
    tc_q   <= tc_d;
    sec4_q <= sel.sector;
  end

  // stage 5: clamp, round and route to phases
  assign qa = to_q15(ta_q);
  assign qb = to_q15(tb_q);
  assign qc = to_q15(tc_q);

  always_comb begin
    case (sec4_q)
      SEC_1: begin
        da_d = qb; db_d = qa; dc_d = qc;
      end
      SEC_2: begin
        da_d = qa; db_d = qc; dc_d = qb;
      end
      SEC_3: begin
        da_d = qa; db_d = qb; dc_d = qc;
      end
      SEC_4: begin
        da_d = qc; db_d = qb; dc_d = qa;
      end
      SEC_5: begin
        da_d = qc; db_d = qa; dc_d = qb;
      end
      SEC_6: begin
        da_d = qb; db_d = qc; dc_d = qa;
      end
      default: begin
        da_d = HALF_Q15; db_d = HALF_Q15; dc_d = HALF_Q15;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    da_q   <= da_d;
    db_q   <= db_d;
    dc_q   <= dc_d;
    sec5_q <= sec4_q;
  end

  // stage 6: scale duties by the timer top into compare counts
  assign pa = da_q * period_top_q;
  assign pb = db_q * period_top_q;
  assign pc = dc_q * period_top_q;

  always_ff @(posedge clk_i) begin
    res_q.sector    <= sec5_q;
    res_q.duty_a    <= da_q;
    res_q.duty_b    <= db_q;
    res_q.duty_c    <= dc_q;
    res_q.compare_a <= pa[30:15];
    res_q.compare_b <= pb[30:15];
    res_q.compare_c <= pc[30:15];
  end

  assign result_valid_o = v6_q;
  assign result_o       = res_q;

`ifndef SYNTH
  // every transfer strobes a result at the end of the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 result_valid_o)
    else $error("result strobe missing after input transfer");

  // duties never exceed one
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.duty_a <= FULL_Q15) &&
      (result_o.duty_b <= FULL_Q15) && (result_o.duty_c <= FULL_Q15))
    else $error("duty above full scale");

  // zero vector gives half duty on all phases
  a_zero_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.sector == SEC_ZERO) |->
      (result_o.duty_a == HALF_Q15) && (result_o.duty_b == HALF_Q15) &&
      (result_o.duty_c == HALF_Q15))
    else $error("zero vector duty not half");

  // sector code seven cannot come out of the sign decode
  a_sector_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.sector != SEC_BAD))
    else $error("invalid sector code");

  // compare counts stay within the timer top
  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.compare_a <= period_top_q) &&
      (result_o.compare_b <= period_top_q) &&
      (result_o.compare_c <= period_top_q))
    else $error("compare count above period top");
`endif

endmodule

@@ rtl/core/svpwm_sector.sv @@
// ----------------------------------------------------------------------------
// svpwm_sector
// Front end: sqrt3 scaling, X/Y/Z, sector decode and t1/t2 selection over
// three register stages.
// ----------------------------------------------------------------------------
module svpwm_sector (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  svpwm_pkg::svpwm_in_t   in_i,
  output svpwm_pkg::svpwm_sel_t  sel_o
);
  import svpwm_pkg::*;

  logic                   v1_q, v2_q, v3_q;
  logic signed [W_SA-1:0] sa_d, sa_q;
  logic signed [15:0]     be1_q, be2_q;
  logic signed [W_T-1:0]  y_d, z_d, y_q, z_q;
  logic signed [W_T-1:0]  x2;
  logic [2:0]             sec_d, sec3_q;
  logic signed [W_T-1:0]  t1_d, t2_d, t1_q, t2_q;

  // stage 1: sqrt3 * alpha
  assign sa_d = W_SA'(in_i.alpha_voltage) * W_SA'(SQRT3_Q16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q  <= sa_d;
    be1_q <= in_i.beta_voltage;
  end

  // stage 2: y and z in Q32
  assign y_d = W_T'(sa_q) + (W_T'(be1_q) <<< 16);
  assign z_d = (W_T'(be1_q) <<< 16) - W_T'(sa_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q   <= y_d;
    z_q   <= z_d;
    be2_q <= be1_q;
  end

  // stage 3: sector from signs, then pick t1 and t2
  assign x2 = W_T'(be2_q) <<< 17;

  always_comb begin
    sec_d = {y_q < 0, z_q < 0, be2_q > 0};
    t1_d  = '0;
    t2_d  = '0;
    case (sec_d)
      SEC_1: begin
        t1_d = z_q;   t2_d = y_q;
      end
      SEC_2: begin
        t1_d = y_q;   t2_d = -x2;
      end
      SEC_3: begin
        t1_d = -z_q;  t2_d = x2;
      end
      SEC_4: begin
        t1_d = -x2;   t2_d = z_q;
      end
      SEC_5: begin
        t1_d = x2;    t2_d = -y_q;
      end
      SEC_6: begin
        t1_d = -y_q;  t2_d = -z_q;
      end
      default: begin
        t1_d = '0;    t2_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sec3_q <= sec_d;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
  end

  assign sel_o = {v3_q, sec3_q, t1_q, t2_q};

endmodule

@@ sim/space_vector_pwm_duty_core_test.sv @@
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_core_test
// Self-checking bench for the space-vector PWM duty core. Drives alpha/beta
// vectors through the start/busy port under random sender gaps and sweeps
// the timer top across its extremes. A fixed-point duty predictor checks the
// sector, the three duties and the three compare counts of every result.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import svpwm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam int unsigned PIPE_SETTLE  = 12;
  localparam int unsigned MAX_REPORTS  = 10;

  // --------------------------------------------------------------------------
  // duty predictor and expected-result store
  // --------------------------------------------------------------------------
  class duty_scoreboard;
    svpwm_out_t expected_duties[$];
    logic [15:0] timer_top;
    int unsigned mismatches;
    int unsigned vectors_seen;
    int unsigned results_seen;
    int unsigned sector_hits[8];

    function new();
      timer_top = 16'd65535;
      mismatches = 0;
      vectors_seen = 0;
      results_seen = 0;
      foreach (sector_hits[i]) sector_hits[i] = 0;
    endfunction

    function void set_top(logic [15:0] top);
      timer_top = top;
    endfunction

    // clamp a doubled on-time (1.0 = 2^33) and round to unsigned Q1.15
    function logic [15:0] q33_to_duty(longint v);
      longint full_scale;
      longint rounded;
      full_scale = longint'(1) << 33;
      if (v < 0) v = 0;
      if (v > full_scale) v = full_scale;
      rounded = (v + 131072) >>> 18;
      return rounded[15:0];
    endfunction

    function logic [15:0] duty_to_compare(logic [15:0] duty);
      longint product;
      product = (longint'(duty) * longint'(timer_top)) >>> 15;
      return product[15:0];
    endfunction

    // projections, sector select, on-time assembly, phase mapping and compare counts
    function svpwm_out_t predict_duties(svpwm_in_t v);
      svpwm_out_t r;
      longint al, be, sa, x, y, z, t1, t2, ta, tb, tc;
      logic [2:0] sec;
      al = $signed(v.alpha_voltage);
      be = $signed(v.beta_voltage);
      sa = al * 113512;
      x = be * 131072;
      y = sa + be * 65536;
      z = be * 65536 - sa;
      sec = {y < 0, z < 0, x > 0};
      t1 = 0;
      t2 = 0;
      case (sec)
        SEC_1: begin t1 = z;  t2 = y;  end
        SEC_2: begin t1 = y;  t2 = -x; end
        SEC_3: begin t1 = -z; t2 = x;  end
        SEC_4: begin t1 = -x; t2 = z;  end
        SEC_5: begin t1 = x;  t2 = -y; end
        SEC_6: begin t1 = -y; t2 = -z; end
        default: ;
      endcase
      ta = (longint'(1) << 32) - t1 - t2;
      tb = ta + 2 * t1;
      tc = tb + 2 * t2;
      r.sector = sec;
      case (sec)
        SEC_1: begin
          r.duty_a = q33_to_duty(tb); r.duty_b = q33_to_duty(ta); r.duty_c = q33_to_duty(tc);
        end
        SEC_2: begin
          r.duty_a = q33_to_duty(ta); r.duty_b = q33_to_duty(tc); r.duty_c = q33_to_duty(tb);
        end
        SEC_3: begin
          r.duty_a = q33_to_duty(ta); r.duty_b = q33_to_duty(tb); r.duty_c = q33_to_duty(tc);
        end
        SEC_4: begin
          r.duty_a = q33_to_duty(tc); r.duty_b = q33_to_duty(tb); r.duty_c = q33_to_duty(ta);
        end
        SEC_5: begin
          r.duty_a = q33_to_duty(tc); r.duty_b = q33_to_duty(ta); r.duty_c = q33_to_duty(tb);
        end
        SEC_6: begin
          r.duty_a = q33_to_duty(tb); r.duty_b = q33_to_duty(tc); r.duty_c = q33_to_duty(ta);
        end
        default: begin
          // zero vector and the impossible code both give half duty
          r.duty_a = HALF_Q15; r.duty_b = HALF_Q15; r.duty_c = HALF_Q15;
        end
      endcase
      r.compare_a = duty_to_compare(r.duty_a);
      r.compare_b = duty_to_compare(r.duty_b);
      r.compare_c = duty_to_compare(r.duty_c);
      return r;
    endfunction

    function void note_vector(svpwm_in_t v);
      svpwm_out_t r;
      r = predict_duties(v);
      sector_hits[r.sector]++;
      vectors_seen++;
      expected_duties.push_back(r);
    endfunction

    function void report(string what, svpwm_out_t e, svpwm_out_t a);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("MISMATCH %s: exp sec=%0d duty=%0d/%0d/%0d cmp=%0d/%0d/%0d",
                 what, e.sector, e.duty_a, e.duty_b, e.duty_c,
                 e.compare_a, e.compare_b, e.compare_c,
                 "\n                  got sec=%0d duty=%0d/%0d/%0d cmp=%0d/%0d/%0d",
                 a.sector, a.duty_a, a.duty_b, a.duty_c,
                 a.compare_a, a.compare_b, a.compare_c);
    endfunction

    function void check_result(svpwm_out_t a);
      svpwm_out_t e;
      string bad;
      results_seen++;
      if (expected_duties.size() == 0) begin
        e = '0;
        report("result with nothing pending", e, a);
        return;
      end
      e = expected_duties.pop_front();
      bad = "";
      if (a.sector    !== e.sector)    bad = {bad, " sector"};
      if (a.duty_a    !== e.duty_a)    bad = {bad, " duty_a"};
      if (a.duty_b    !== e.duty_b)    bad = {bad, " duty_b"};
      if (a.duty_c    !== e.duty_c)    bad = {bad, " duty_c"};
      if (a.compare_a !== e.compare_a) bad = {bad, " compare_a"};
      if (a.compare_b !== e.compare_b) bad = {bad, " compare_b"};
      if (a.compare_c !== e.compare_c) bad = {bad, " compare_c"};
      if (bad != "") report(bad, e, a);
    endfunction

    function int unsigned pending();
      return expected_duties.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  svpwm_in_t   in_data_i = '0;
  logic        result_valid_o;
  svpwm_out_t  result_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  duty_scoreboard duty_sb = new();
  int unsigned cycle_count = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  space_vector_pwm_duty_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_data_i      (in_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // watch both channels at the edge: results first, then the input transfer
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (result_valid_o) duty_sb.check_result(result_o);
      if (start_i && !busy_o) duty_sb.note_vector(in_data_i);
    end
  end

  // run guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, duty_sb.pending());
    $display("space_vector_pwm_duty_core verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // drive tasks
  // --------------------------------------------------------------------------
  function automatic svpwm_in_t pack_vector(int alpha, int beta);
    svpwm_in_t v;
    v.alpha_voltage = alpha[15:0];
    v.beta_voltage  = beta[15:0];
    return v;
  endfunction

  // random vector: full range, linear region, near zero, sector borders and full-scale corners
  function automatic svpwm_in_t random_vector();
    int unsigned pick;
    int k;
    pick = $urandom_range(99);
    if (pick < 35) begin
      return pack_vector($urandom, $urandom);
    end else if (pick < 70) begin
      return pack_vector(int'($urandom_range(26000)) - 13000,
                         int'($urandom_range(26000)) - 13000);
    end else if (pick < 85) begin
      return pack_vector(int'($urandom_range(512)) - 256,
                         int'($urandom_range(512)) - 256);
    end else if (pick < 93) begin
      // projections that land exactly on zero
      k = $urandom_range(1, 2);
      return pack_vector(($urandom_range(1) ? 8192 : -8192) * k,
                         ($urandom_range(1) ? 14189 : -14189) * k);
    end else begin
      return pack_vector($urandom_range(1) ? 32767 : -32768,
                         $urandom_range(2) == 0 ? 0 :
                         ($urandom_range(1) ? 32767 : -32768));
    end
  endfunction

  // one transfer, with idle cycles of noise beforehand at gap_pct per cycle
  task automatic send_vector(svpwm_in_t v, int unsigned gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      in_data_i <= pack_vector($urandom, $urandom);
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_data_i <= v;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  // hold the sender until every pending result is back, then let it settle
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (duty_sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_top(logic [15:0] top);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= top;
    @(posedge clk_i);
    duty_sb.set_top(top);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  int directed_alpha[] = '{0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768,
                           1, -1, 0, 0, 8660, 0, -8660, -8660, 0, 8660,
                           8192, 8192, -8192, -8192};
  int directed_beta[]  = '{0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767,
                           0, 0, 1, -1, 5000, 10000, 5000, -5000, -10000, -5000,
                           14189, -14189, 14189, -14189};
  logic [15:0] phase_top[7];
  int unsigned phase_gap[7];
  string top_list;

  initial begin
    phase_top = '{16'd1, 16'd0, 16'd65535, 16'd32768,
                  16'($urandom_range(2, 65534)), 16'($urandom_range(2, 65534)),
                  16'($urandom_range(2, 65534))};
    // light gaps, then heavy gaps, then back to back
    phase_gap = '{18, 18, 18, 69, 69, 0, 0};
    top_list = "65535";

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners at the reset top
    foreach (directed_alpha[i])
      send_vector(pack_vector(directed_alpha[i], directed_beta[i]), 18);

    // random phases, each at its own timer top
    for (int p = 0; p < 7; p++) begin
      write_top(phase_top[p]);
      top_list = {top_list, $sformatf(" %0d", phase_top[p])};
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_vector(random_vector(), phase_gap[p]);
        if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
      end
    end

    drain_results();

    $display("covered %0d vectors, %0d results; sector hits 0..6: %0d %0d %0d %0d %0d %0d %0d",
             duty_sb.vectors_seen, duty_sb.results_seen, duty_sb.sector_hits[0],
             duty_sb.sector_hits[1], duty_sb.sector_hits[2], duty_sb.sector_hits[3],
             duty_sb.sector_hits[4], duty_sb.sector_hits[5], duty_sb.sector_hits[6]);
    $display("timer tops used: %s; mismatches %0d, left pending %0d",
             top_list, duty_sb.mismatches, duty_sb.pending());
    if (duty_sb.mismatches == 0 && duty_sb.pending() == 0) begin
      $display("space_vector_pwm_duty_core verification clean");
    end else begin
      $display("space_vector_pwm_duty_core verification failed");
    end
    $finish;
  end

endmodule

@@ space_vector_pwm_duty_core.f @@
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_sector.sv
rtl/core/space_vector_pwm_duty_core.sv
sim/space_vector_pwm_duty_core_test.sv
